// ===== src/cbm_pkg.sv =====
// Shared types, codes and address map for the CPU bus map with video ports.
// No dependencies; the other files, apart from cbm_ram, use these by scoped name.
package cbm_pkg;

   localparam int RAM_DEPTH     = 2048;
   localparam int PROGRAM_DEPTH = 32768;
   localparam int SPRITE_DEPTH  = 256;

   localparam int RAM_AW  = $clog2(RAM_DEPTH);
   localparam int PROG_AW = $clog2(PROGRAM_DEPTH);
   localparam int SPR_AW  = $clog2(SPRITE_DEPTH);

   // opcodes
   localparam logic [2:0] OP_READ         = 3'd0;
   localparam logic [2:0] OP_WRITE        = 3'd1;
   localparam logic [2:0] OP_SET_BUTTONS  = 3'd2;
   localparam logic [2:0] OP_LOAD_PROGRAM = 3'd3;
   localparam logic [2:0] OP_SET_STATUS   = 3'd4;

   // video register ports
   localparam logic [2:0] PORT_CTRL    = 3'd0;
   localparam logic [2:0] PORT_MASK    = 3'd1;
   localparam logic [2:0] PORT_STATUS  = 3'd2;
   localparam logic [2:0] PORT_OAM_ADR = 3'd3;
   localparam logic [2:0] PORT_OAM_DAT = 3'd4;
   localparam logic [2:0] PORT_SCROLL  = 3'd5;
   localparam logic [2:0] PORT_ADDR    = 3'd6;
   localparam logic [2:0] PORT_DATA    = 3'd7;

   localparam logic [15:0] VIDEO_BASE = 16'h2000;
   localparam logic [15:0] IO_BASE    = 16'h4000;
   localparam logic [15:0] DMA_ADDR   = 16'h4014;
   localparam logic [15:0] PAD_ADDR   = 16'h4016;
   localparam logic [15:0] ROM_BASE   = 16'h8000;
   localparam logic [7:0]  PAD_OPEN   = 8'h40;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [15:0] address;
      logic [7:0]  value;
   } req_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic        data_port_hit;
      logic        data_port_write;
      logic [7:0]  ppu_ctrl;
      logic [7:0]  ppu_mask;
      logic [14:0] vram_address;
      logic [14:0] temp_address;
      logic [2:0]  fine_x;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic clear_step;
      logic load_req;
      logic apply;
      logic dma_start;
      logic dma_sel;
      logic dma_apply;
      logic finish;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clear_last;
      logic dma_req;
      logic dma_last;
   } stat_type;

   function automatic logic is_ram_addr(input logic [15:0] a);
      return a < VIDEO_BASE;
   endfunction

   function automatic logic is_video_addr(input logic [15:0] a);
      return (a >= VIDEO_BASE) && (a < IO_BASE);
   endfunction

   function automatic logic is_rom_addr(input logic [15:0] a);
      return a >= ROM_BASE;
   endfunction

endpackage

// ===== src/cbm_if.sv =====
// Request and response channel interfaces (valid/ready plus payload).
// Depends on cbm_pkg for the payload types.
interface cbm_req_if;
   logic             valid;
   logic             ready;
   cbm_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface cbm_rsp_if;
   logic             valid;
   logic             ready;
   cbm_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/cbm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cbm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/cbm_datapath.sv =====
// Datapath: request latch, video/pad registers, the three memories,
// sprite copy counter, clear counter and the response register.
// Depends on cbm_pkg and cbm_ram.
module cbm_datapath (
   input  logic              clock,
   input  logic              reset,
   input  cbm_pkg::cmd_type  cmd,
   output cbm_pkg::stat_type stat,
   input  cbm_pkg::req_type  req_in,
   output cbm_pkg::rsp_type  rsp_out
);

   cbm_pkg::req_type req_ff;

   logic [7:0]  sprite_addr_ff, sprite_addr_in;
   logic [7:0]  ctrl_ff, ctrl_in;
   logic [7:0]  mask_ff, mask_in;
   logic [7:0]  status_ff, status_in;
   logic [14:0] temp_ff, temp_in;
   logic [14:0] vram_ff, vram_in;
   logic [2:0]  fine_ff, fine_in;
   logic        toggle_ff, toggle_in;
   logic        strobe_ff, strobe_in;
   logic [7:0]  shift_ff, shift_in;
   logic [7:0]  buttons_ff, buttons_in;
   logic [cbm_pkg::RAM_AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic [cbm_pkg::SPR_AW-1:0] dma_cnt_ff, dma_cnt_in;
   logic        dma_hit_ff, dma_hit_in;

   logic [7:0]  rd_data_ff;
   logic        hit_ff;
   logic        pwrite_ff;

   logic [15:0] ea;
   logic [2:0]  port;
   logic        in_video;
   logic        rd_hit;
   logic [7:0]  bus_rd_data;
   logic        do_read;
   logic        do_write;
   logic        status_rd;
   logic        addr_second;

   logic [7:0]  ram_rd, rom_rd, spr_rd;
   logic        ram_we, rom_we, spr_we;
   logic [cbm_pkg::RAM_AW-1:0] ram_waddr;
   logic [7:0]  ram_wdata;
   logic [cbm_pkg::SPR_AW-1:0] spr_waddr;
   logic [7:0]  spr_wdata;

   // during a sprite copy the bus address walks the source page
   assign ea       = cmd.dma_sel ? {req_ff.value, dma_cnt_ff} : req_ff.address;
   assign port     = ea[2:0];
   assign in_video = cbm_pkg::is_video_addr(ea);
   assign rd_hit   = in_video && (port == cbm_pkg::PORT_DATA);
   assign do_read  = (cmd.apply && (req_ff.opcode == cbm_pkg::OP_READ)) || cmd.dma_apply;
   assign do_write = cmd.apply && (req_ff.opcode == cbm_pkg::OP_WRITE);
   assign status_rd   = do_read && in_video && (port == cbm_pkg::PORT_STATUS);
   assign addr_second = do_write && in_video && (port == cbm_pkg::PORT_ADDR) && toggle_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_in;
      end
   end

   // ---- memories ----
   assign ram_we    = cmd.clear_step || (do_write && cbm_pkg::is_ram_addr(ea));
   assign ram_waddr = cmd.clear_step ? clr_cnt_ff : ea[cbm_pkg::RAM_AW-1:0];
   assign ram_wdata = cmd.clear_step ? 8'd0 : req_ff.value;

   cbm_ram #(.WIDTH(8), .DEPTH(cbm_pkg::RAM_DEPTH)) u_work_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ea[cbm_pkg::RAM_AW-1:0]),
      .rd_data (ram_rd)
   );

   assign rom_we = cmd.apply && (req_ff.opcode == cbm_pkg::OP_LOAD_PROGRAM);

   cbm_ram #(.WIDTH(8), .DEPTH(cbm_pkg::PROGRAM_DEPTH)) u_program_rom (
      .clock   (clock),
      .wr_en   (rom_we),
      .wr_addr (req_ff.address[cbm_pkg::PROG_AW-1:0]),
      .wr_data (req_ff.value),
      .rd_addr (ea[cbm_pkg::PROG_AW-1:0]),
      .rd_data (rom_rd)
   );

   always_comb begin
      spr_we    = 1'b0;
      spr_waddr = sprite_addr_ff;
      spr_wdata = req_ff.value;
      priority if (cmd.clear_step) begin
         spr_we    = (clr_cnt_ff[cbm_pkg::RAM_AW-1:cbm_pkg::SPR_AW] == '0);
         spr_waddr = clr_cnt_ff[cbm_pkg::SPR_AW-1:0];
         spr_wdata = 8'd0;
      end else if (cmd.dma_apply) begin
         spr_we    = 1'b1;
         spr_waddr = dma_cnt_ff;
         spr_wdata = bus_rd_data;
      end else begin
         spr_we = do_write && in_video && (port == cbm_pkg::PORT_OAM_DAT);
      end
   end

   cbm_ram #(.WIDTH(8), .DEPTH(cbm_pkg::SPRITE_DEPTH)) u_sprite_mem (
      .clock   (clock),
      .wr_en   (spr_we),
      .wr_addr (spr_waddr),
      .wr_data (spr_wdata),
      .rd_addr (sprite_addr_ff),
      .rd_data (spr_rd)
   );

   // ---- bus read mux ----
   always_comb begin
      bus_rd_data = 8'd0;
      priority if (cbm_pkg::is_ram_addr(ea)) begin
         bus_rd_data = ram_rd;
      end else if (in_video) begin
         unique case (port)
            cbm_pkg::PORT_STATUS:  bus_rd_data = status_ff;
            cbm_pkg::PORT_OAM_DAT: bus_rd_data = spr_rd;
            default:               bus_rd_data = 8'd0;
         endcase
      end else if (ea == cbm_pkg::PAD_ADDR) begin
         bus_rd_data = cbm_pkg::PAD_OPEN | {7'd0, shift_ff[0]};
      end else if (cbm_pkg::is_rom_addr(ea)) begin
         bus_rd_data = rom_rd;
      end else begin
         bus_rd_data = 8'd0;
      end
   end

   // ---- register next values ----
   always_comb begin
      sprite_addr_in = sprite_addr_ff;
      ctrl_in        = ctrl_ff;
      mask_in        = mask_ff;
      status_in      = status_ff;
      temp_in        = temp_ff;
      vram_in        = vram_ff;
      fine_in        = fine_ff;
      toggle_in      = toggle_ff;
      strobe_in      = strobe_ff;
      shift_in       = shift_ff;
      buttons_in     = buttons_ff;
      clr_cnt_in     = clr_cnt_ff;
      dma_cnt_in     = dma_cnt_ff;
      dma_hit_in     = dma_hit_ff;

      if (cmd.clear_step) begin
         clr_cnt_in = clr_cnt_ff + {{(cbm_pkg::RAM_AW-1){1'b0}}, 1'b1};
      end

      if (cmd.dma_start) begin
         dma_cnt_in = '0;
         dma_hit_in = 1'b0;
      end
      if (cmd.dma_apply) begin
         dma_cnt_in = dma_cnt_ff + {{(cbm_pkg::SPR_AW-1){1'b0}}, 1'b1};
         dma_hit_in = dma_hit_ff | rd_hit;
      end

      if (do_read) begin
         if (status_rd) begin
            status_in = {1'b0, status_ff[6:0]};
            toggle_in = 1'b0;
         end else if ((ea == cbm_pkg::PAD_ADDR) && !strobe_ff) begin
            shift_in = {1'b0, shift_ff[7:1]};
         end
      end

      if (do_write) begin
         if (in_video) begin
            unique case (port)
               cbm_pkg::PORT_CTRL: begin
                  ctrl_in        = req_ff.value;
                  temp_in[11:10] = req_ff.value[1:0];
               end
               cbm_pkg::PORT_MASK:    mask_in = req_ff.value;
               cbm_pkg::PORT_OAM_ADR: sprite_addr_in = req_ff.value;
               cbm_pkg::PORT_OAM_DAT: sprite_addr_in = sprite_addr_ff + 8'd1;
               cbm_pkg::PORT_SCROLL: begin
                  if (!toggle_ff) begin
                     fine_in      = req_ff.value[2:0];
                     temp_in[4:0] = req_ff.value[7:3];
                  end else begin
                     temp_in[14:12] = req_ff.value[2:0];
                     temp_in[9:5]   = req_ff.value[7:3];
                  end
                  toggle_in = !toggle_ff;
               end
               cbm_pkg::PORT_ADDR: begin
                  if (!toggle_ff) begin
                     temp_in[14]   = 1'b0;
                     temp_in[13:8] = req_ff.value[5:0];
                  end else begin
                     temp_in[7:0] = req_ff.value;
                     vram_in      = {temp_ff[14:8], req_ff.value};
                  end
                  toggle_in = !toggle_ff;
               end
               default: ;
            endcase
         end else if (req_ff.address == cbm_pkg::PAD_ADDR) begin
            strobe_in = req_ff.value[0];
            if (req_ff.value[0]) begin
               shift_in = buttons_ff;
            end
         end
      end

      if (cmd.apply && (req_ff.opcode == cbm_pkg::OP_SET_BUTTONS)) begin
         buttons_in = req_ff.value;
         if (strobe_ff) begin
            shift_in = req_ff.value;
         end
      end
      if (cmd.apply && (req_ff.opcode == cbm_pkg::OP_SET_STATUS)) begin
         status_in = req_ff.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sprite_addr_ff <= '0;
         ctrl_ff        <= '0;
         mask_ff        <= '0;
         status_ff      <= '0;
         temp_ff        <= '0;
         vram_ff        <= '0;
         fine_ff        <= '0;
         toggle_ff      <= 1'b0;
         strobe_ff      <= 1'b0;
         shift_ff       <= '0;
         buttons_ff     <= '0;
         clr_cnt_ff     <= '0;
         dma_cnt_ff     <= '0;
         dma_hit_ff     <= 1'b0;
      end else begin
         sprite_addr_ff <= sprite_addr_in;
         ctrl_ff        <= ctrl_in;
         mask_ff        <= mask_in;
         status_ff      <= status_in;
         temp_ff        <= temp_in;
         vram_ff        <= vram_in;
         fine_ff        <= fine_in;
         toggle_ff      <= toggle_in;
         strobe_ff      <= strobe_in;
         shift_ff       <= shift_in;
         buttons_ff     <= buttons_in;
         clr_cnt_ff     <= clr_cnt_in;
         dma_cnt_ff     <= dma_cnt_in;
         dma_hit_ff     <= dma_hit_in;
      end
   end

   // response word; register fields come straight from state, which
   // stays put while the word waits
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         if (cmd.dma_sel) begin
            rd_data_ff <= 8'd0;
            hit_ff     <= dma_hit_ff | rd_hit;
            pwrite_ff  <= 1'b0;
         end else begin
            rd_data_ff <= (req_ff.opcode == cbm_pkg::OP_READ) ? bus_rd_data : 8'd0;
            hit_ff     <= rd_hit && ((req_ff.opcode == cbm_pkg::OP_READ) ||
                                     (req_ff.opcode == cbm_pkg::OP_WRITE));
            pwrite_ff  <= rd_hit && (req_ff.opcode == cbm_pkg::OP_WRITE);
         end
      end
   end

   assign rsp_out.read_data       = rd_data_ff;
   assign rsp_out.data_port_hit   = hit_ff;
   assign rsp_out.data_port_write = pwrite_ff;
   assign rsp_out.ppu_ctrl        = ctrl_ff;
   assign rsp_out.ppu_mask        = mask_ff;
   assign rsp_out.vram_address    = vram_ff;
   assign rsp_out.temp_address    = temp_ff;
   assign rsp_out.fine_x          = fine_ff;

   assign stat.clear_last = &clr_cnt_ff;
   assign stat.dma_req    = (req_ff.opcode == cbm_pkg::OP_WRITE) &&
                            (req_ff.address == cbm_pkg::DMA_ADDR);
   assign stat.dma_last   = &dma_cnt_ff;

   a_addr_copy: assert property (@(posedge clock) disable iff (reset)
      addr_second |=> (vram_ff == temp_ff))
      else $error("vram address not loaded from temp on second address write");

   a_dma_wrap: assert property (@(posedge clock) disable iff (reset)
      (cmd.dma_apply && stat.dma_last) |=> (dma_cnt_ff == '0))
      else $error("sprite copy counter did not wrap after last byte");

   a_status_clr: assert property (@(posedge clock) disable iff (reset)
      status_rd |=> (!status_ff[7] && !toggle_ff))
      else $error("status read did not clear vblank bit and toggle");

endmodule

// ===== src/cbm_ctrl.sv =====
// Controller: reset clearing pass, per-word sequencing, sprite page copy
// loop and the response valid flag. Depends on cbm_pkg.
module cbm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  cbm_pkg::stat_type stat,
   output cbm_pkg::cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ISSUE,
      ST_APPLY,
      ST_DMA_ISSUE,
      ST_DMA_APPLY
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.clear_step = (state_ff == ST_CLEAR);
      cmd.load_req   = accept;
      cmd.apply      = (state_ff == ST_APPLY) && !stat.dma_req;
      cmd.dma_start  = (state_ff == ST_APPLY) && stat.dma_req;
      cmd.dma_sel    = (state_ff == ST_DMA_ISSUE) || (state_ff == ST_DMA_APPLY);
      cmd.dma_apply  = (state_ff == ST_DMA_APPLY);
      cmd.finish     = ((state_ff == ST_APPLY) && !stat.dma_req) ||
                       ((state_ff == ST_DMA_APPLY) && stat.dma_last);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_CLEAR: begin
               if (stat.clear_last) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (accept) state_ff <= ST_ISSUE;
            end
            ST_ISSUE: state_ff <= ST_APPLY;
            ST_APPLY: begin
               state_ff <= stat.dma_req ? ST_DMA_ISSUE : ST_IDLE;
            end
            ST_DMA_ISSUE: state_ff <= ST_DMA_APPLY;
            ST_DMA_APPLY: begin
               state_ff <= stat.dma_last ? ST_IDLE : ST_DMA_ISSUE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_accept_free: assert property (@(posedge clock) disable iff (reset)
      accept |=> !rsp_valid_ff)
      else $error("response register still full after accepting a word");

   a_finish_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !rsp_valid_ff)
      else $error("result finished while response register full");

   a_dma_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DMA_APPLY) |-> ($past(state_ff) == ST_DMA_ISSUE))
      else $error("sprite copy byte applied without a read issue cycle");

endmodule

// ===== src/cpu_bus_map_ppu_ports.sv =====
// Top level of the CPU bus map with video register ports and pad port.
// Depends on cbm_pkg, cbm_if, cbm_ram, cbm_datapath and cbm_ctrl.
//
//   channel  dir  handshake    word
//   req_bus  in   valid/ready  opcode, address, value
//   rsp_bus  out  valid/ready  read_data, port flags, video registers
//
// After reset the block runs a pass zeroing work RAM and sprite memory;
// req_bus.ready stays low until it ends.
// One word at a time, in the steps latch, RAM read and apply; the result
// is registered in the apply step, once the registered memory read is in.
// A write to 0x4014 copies 256 bytes from the page named by the value,
// each a read issue, then a write into sprite memory.
// A new word is taken while the previous result waits in the output
// register, as long as that result is taken in the same cycle.
module cpu_bus_map_ppu_ports (
   input  logic      clock,
   input  logic      reset,
   cbm_req_if.sink   req_bus,
   cbm_rsp_if.source rsp_bus
);

   cbm_pkg::cmd_type  cmd;
   cbm_pkg::stat_type stat;
   cbm_pkg::rsp_type  rsp_word;

   cbm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   cbm_datapath u_datapath (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .stat    (stat),
      .req_in  (req_bus.payload),
      .rsp_out (rsp_word)
   );

   assign rsp_bus.payload = rsp_word;

endmodule
